>>> hw/rtl/ppm_p6_stream_parser_top_macros.svh
// Assertion macros used by the PPM P6 parser controller.
`ifndef PPM_P6_STREAM_PARSER_TOP_MACROS_SVH
`define PPM_P6_STREAM_PARSER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk with rst_n low disabling the check.
`define PPM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk with rst_n low disabling the check.
`define PPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ppm_pkg.sv
// Shared constants, codes and control structs of the PPM P6 parser.
`timescale 1ns / 1ps
package ppm_pkg;

  localparam int MAX_TOKEN_LEN = 4096;
  localparam int TOKEN_LEN_W   = $clog2(MAX_TOKEN_LEN);

  localparam int SIZE_W = 35;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PIX = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [1:0] ERR_TRUNC     = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
  localparam logic [1:0] ERR_BAD_START = 2'd2;

  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_6    = 8'h36;
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_SP   = 8'h20;
  localparam logic [7:0] CHAR_TAB  = 8'h09;
  localparam logic [7:0] CHAR_VT   = 8'h0B;
  localparam logic [7:0] CHAR_FF   = 8'h0C;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_0    = 8'h30;
  localparam logic [7:0] CHAR_9    = 8'h39;

  localparam logic [15:0] DEPTH_8BIT_MAX = 16'd255;

  typedef struct packed {
    logic       tok_start;
    logic       tok_add;
    logic       tok_finish;
    logic       mul;
    logic       size;
    logic       pay_step;
    logic       clear;
    logic       out_load;
    logic [1:0] out_kind;
    logic [1:0] out_err;
  } ppm_cmd_t;

  typedef struct packed {
    logic is_ws;
    logic is_hash;
    logic is_nl;
    logic is_p;
    logic is_6;
    logic is_high;
    logic tok_full;
    logic tok_third;
    logic rem_one;
    logic size_zero;
    logic out_free;
  } ppm_sts_t;

endpackage

>>> hw/rtl/ppm_byte_if.sv
// Input byte channel of the PPM P6 parser.
`timescale 1ns / 1ps
interface ppm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

>>> hw/rtl/ppm_res_if.sv
// Result channel of the PPM P6 parser.
`timescale 1ns / 1ps
interface ppm_res_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic [7:0]                pixel_byte;
  logic [15:0]               image_width;
  logic [15:0]               image_height;
  logic [15:0]               max_value;
  logic [ppm_pkg::SIZE_W-1:0] payload_size;
  logic [1:0]                error_code;
  logic                      last_payload;

  modport source (output valid, output kind, output pixel_byte, output image_width,
                  output image_height, output max_value, output payload_size,
                  output error_code, output last_payload, input ready);
  modport sink (input valid, input kind, input pixel_byte, input image_width,
                input image_height, input max_value, input payload_size,
                input error_code, input last_payload, output ready);
endinterface

>>> hw/rtl/ppm_datapath.sv
// Datapath: byte decode, token accumulation, size arithmetic and result register.
`timescale 1ns / 1ps
module ppm_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        in_data_byte,
  input  ppm_pkg::ppm_cmd_t cmd,
  output ppm_pkg::ppm_sts_t sts,
  ppm_res_if.source         out_chan
);

  logic [15:0] acc_r, acc_nxt;
  logic        ended_r, ended_nxt;
  logic [15:0] base_acc;
  logic        base_ended;
  logic [19:0] acc_x10;
  logic [ppm_pkg::TOKEN_LEN_W-1:0] len_r;
  logic [1:0]  tok_num_r;
  logic [15:0] width_r, height_r, maxval_r;
  logic [31:0] product_r;
  logic [33:0] prod_x3;
  logic [ppm_pkg::SIZE_W-1:0] size_r, size_nxt, rem_r;
  logic        is_digit;

  logic                       out_valid_r;
  logic [1:0]                 out_kind_r;
  logic [7:0]                 out_pix_r;
  logic [15:0]                out_w_r, out_h_r, out_max_r;
  logic [ppm_pkg::SIZE_W-1:0] out_size_r;
  logic [1:0]                 out_err_r;
  logic                       out_last_r;
  logic                       out_free;

  assign is_digit = (in_data_byte >= ppm_pkg::CHAR_0) && (in_data_byte <= ppm_pkg::CHAR_9);
  assign out_free = !out_valid_r || out_chan.ready;

  always_comb begin
    sts.is_ws     = (in_data_byte == ppm_pkg::CHAR_SP) || (in_data_byte == ppm_pkg::CHAR_TAB) ||
                    (in_data_byte == ppm_pkg::CHAR_NL) || (in_data_byte == ppm_pkg::CHAR_VT) ||
                    (in_data_byte == ppm_pkg::CHAR_FF) || (in_data_byte == ppm_pkg::CHAR_CR);
    sts.is_hash   = in_data_byte == ppm_pkg::CHAR_HASH;
    sts.is_nl     = in_data_byte == ppm_pkg::CHAR_NL;
    sts.is_p      = in_data_byte == ppm_pkg::CHAR_P;
    sts.is_6      = in_data_byte == ppm_pkg::CHAR_6;
    sts.is_high   = in_data_byte[7];
    sts.tok_full  = len_r >= ppm_pkg::TOKEN_LEN_W'(ppm_pkg::MAX_TOKEN_LEN - 1);
    sts.tok_third = tok_num_r == 2'd2;
    sts.rem_one   = rem_r == ppm_pkg::SIZE_W'(1);
    sts.size_zero = size_r == '0;
    sts.out_free  = out_free;
  end

  // Digit accumulation; a token that finishes on this byte sees the updated value.
  always_comb begin
    base_acc   = cmd.tok_start ? 16'd0 : acc_r;
    base_ended = cmd.tok_start ? 1'b0 : ended_r;
    acc_x10    = {4'd0, base_acc} * 20'd10 + {16'd0, in_data_byte[3:0]};
    acc_nxt    = acc_r;
    ended_nxt  = ended_r;
    if (cmd.tok_start || cmd.tok_add) begin
      if (!base_ended && is_digit) begin
        acc_nxt   = (acc_x10 > 20'd65535) ? 16'hFFFF : acc_x10[15:0];
        ended_nxt = base_ended;
      end else begin
        acc_nxt   = base_acc;
        ended_nxt = 1'b1;
      end
    end
  end

  assign prod_x3  = {1'b0, product_r, 1'b0} + {2'b00, product_r};
  assign size_nxt = (maxval_r > ppm_pkg::DEPTH_8BIT_MAX) ? {prod_x3, 1'b0} : {1'b0, prod_x3};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_num_r <= '0;
      acc_r     <= '0;
      ended_r   <= 1'b0;
      len_r     <= '0;
      width_r   <= '0;
      height_r  <= '0;
      rem_r     <= '0;
    end else begin
      acc_r   <= acc_nxt;
      ended_r <= ended_nxt;
      if (cmd.tok_start) begin
        len_r <= ppm_pkg::TOKEN_LEN_W'(1);
      end else if (cmd.tok_add) begin
        len_r <= len_r + ppm_pkg::TOKEN_LEN_W'(1);
      end
      if (cmd.tok_finish) begin
        case (tok_num_r)
          2'd0:    width_r  <= acc_nxt;
          2'd1:    height_r <= acc_nxt;
          default: maxval_r <= acc_nxt;
        endcase
        tok_num_r <= tok_num_r + 2'd1;
      end
      if (cmd.size) begin
        rem_r <= size_nxt;
      end else if (cmd.pay_step) begin
        rem_r <= rem_r - ppm_pkg::SIZE_W'(1);
      end
      if (cmd.clear) begin
        tok_num_r <= '0;
        acc_r     <= '0;
        ended_r   <= 1'b0;
        len_r     <= '0;
        width_r   <= '0;
        height_r  <= '0;
        rem_r     <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      product_r <= width_r * height_r;
    end
    if (cmd.size) begin
      size_r <= size_nxt;
    end
  end

  // Result register; fields that do not belong to the kind read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind_r <= cmd.out_kind;
      out_pix_r  <= '0;
      out_w_r    <= '0;
      out_h_r    <= '0;
      out_max_r  <= '0;
      out_size_r <= '0;
      out_err_r  <= '0;
      out_last_r <= 1'b0;
      case (cmd.out_kind)
        ppm_pkg::KIND_HDR: begin
          out_w_r    <= width_r;
          out_h_r    <= height_r;
          out_max_r  <= maxval_r;
          out_size_r <= size_r;
        end
        ppm_pkg::KIND_PIX: begin
          out_pix_r  <= in_data_byte;
          out_last_r <= rem_r == ppm_pkg::SIZE_W'(1);
        end
        ppm_pkg::KIND_ERR: begin
          out_err_r <= cmd.out_err;
        end
        default: begin
          out_err_r <= '0;
        end
      endcase
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.kind         = out_kind_r;
  assign out_chan.pixel_byte   = out_pix_r;
  assign out_chan.image_width  = out_w_r;
  assign out_chan.image_height = out_h_r;
  assign out_chan.max_value    = out_max_r;
  assign out_chan.payload_size = out_size_r;
  assign out_chan.error_code   = out_err_r;
  assign out_chan.last_payload = out_last_r;

endmodule

>>> hw/rtl/ppm_ctrl.sv
// Controller: parse phase and header/error sequencing of the PPM P6 parser.
`timescale 1ns / 1ps
`include "ppm_p6_stream_parser_top_macros.svh"
module ppm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_end,
  output logic              in_ready,
  input  ppm_pkg::ppm_sts_t sts,
  output ppm_pkg::ppm_cmd_t cmd
);

  localparam logic [3:0] ST_MAGIC_P  = 4'd0;
  localparam logic [3:0] ST_MAGIC_6  = 4'd1;
  localparam logic [3:0] ST_MAGIC_WS = 4'd2;
  localparam logic [3:0] ST_SKIP     = 4'd3;
  localparam logic [3:0] ST_COMMENT  = 4'd4;
  localparam logic [3:0] ST_TOKEN    = 4'd5;
  localparam logic [3:0] ST_PAYLOAD  = 4'd6;
  localparam logic [3:0] ST_IDLE     = 4'd7;
  localparam logic [3:0] ST_MUL      = 4'd8;
  localparam logic [3:0] ST_SIZE     = 4'd9;
  localparam logic [3:0] ST_HDR      = 4'd10;
  localparam logic [3:0] ST_ERR0     = 4'd11;

  logic [3:0] state_r, state_nxt, ph;
  logic       end_r, end_nxt;
  logic       acc, loaded, to_mul;

  assign in_ready = (state_r <= ST_IDLE) && sts.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    end_nxt   = end_r;
    ph        = state_r;
    loaded    = 1'b0;
    to_mul    = 1'b0;
    if (acc) begin
      case (state_r)
        ST_MAGIC_P: begin
          ph = sts.is_p ? ST_MAGIC_6 : ST_MAGIC_P;
        end
        ST_MAGIC_6: begin
          ph = sts.is_6 ? ST_MAGIC_WS : ST_MAGIC_P;
        end
        ST_MAGIC_WS: begin
          ph = sts.is_ws ? ST_SKIP : ST_MAGIC_P;
        end
        ST_SKIP: begin
          if (sts.is_ws) begin
            ph = ST_SKIP;
          end else if (sts.is_hash) begin
            ph = ST_COMMENT;
          end else if (sts.is_high) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = ppm_pkg::KIND_ERR;
            cmd.out_err  = ppm_pkg::ERR_BAD_START;
            loaded       = 1'b1;
            ph           = ST_IDLE;
          end else begin
            cmd.tok_start = 1'b1;
            ph            = ST_TOKEN;
            if (in_end) begin
              cmd.tok_finish = 1'b1;
              to_mul         = sts.tok_third;
              ph             = ST_SKIP;
            end
          end
        end
        ST_COMMENT: begin
          ph = sts.is_nl ? ST_SKIP : ST_COMMENT;
        end
        ST_TOKEN: begin
          if (sts.is_ws) begin
            cmd.tok_finish = 1'b1;
            to_mul         = sts.tok_third;
            ph             = ST_SKIP;
          end else if (sts.tok_full) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = ppm_pkg::KIND_ERR;
            cmd.out_err  = ppm_pkg::ERR_TOO_LONG;
            loaded       = 1'b1;
            ph           = ST_IDLE;
          end else begin
            cmd.tok_add = 1'b1;
            if (in_end) begin
              cmd.tok_finish = 1'b1;
              to_mul         = sts.tok_third;
              ph             = ST_SKIP;
            end
          end
        end
        ST_PAYLOAD: begin
          cmd.out_load = 1'b1;
          cmd.out_kind = ppm_pkg::KIND_PIX;
          cmd.pay_step = 1'b1;
          loaded       = 1'b1;
          ph           = sts.rem_one ? ST_IDLE : ST_PAYLOAD;
        end
        default: begin
          ph = ST_IDLE;
        end
      endcase

      // A stream end restarts the search; an unfinished image also reports truncation.
      if (to_mul) begin
        state_nxt = ST_MUL;
        end_nxt   = in_end;
      end else if (in_end) begin
        if ((ph != ST_IDLE) && loaded) begin
          state_nxt = ST_ERR0;
        end else begin
          if (ph != ST_IDLE) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = ppm_pkg::KIND_ERR;
            cmd.out_err  = ppm_pkg::ERR_TRUNC;
          end
          cmd.clear = 1'b1;
          state_nxt = ST_MAGIC_P;
        end
      end else begin
        state_nxt = ph;
      end
    end else begin
      case (state_r)
        ST_MUL: begin
          cmd.mul   = 1'b1;
          state_nxt = ST_SIZE;
        end
        ST_SIZE: begin
          cmd.size  = 1'b1;
          state_nxt = ST_HDR;
        end
        ST_HDR: begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = ppm_pkg::KIND_HDR;
            if (end_r) begin
              if (sts.size_zero) begin
                cmd.clear = 1'b1;
                state_nxt = ST_MAGIC_P;
              end else begin
                state_nxt = ST_ERR0;
              end
            end else begin
              state_nxt = sts.size_zero ? ST_IDLE : ST_PAYLOAD;
            end
          end
        end
        ST_ERR0: begin
          if (sts.out_free) begin
            cmd.out_load = 1'b1;
            cmd.out_kind = ppm_pkg::KIND_ERR;
            cmd.out_err  = ppm_pkg::ERR_TRUNC;
            cmd.clear    = 1'b1;
            state_nxt    = ST_MAGIC_P;
          end
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_MAGIC_P;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      end_r   <= end_nxt;
    end
  end

  `PPM_ASSERT_SAME(a_load_into_free, cmd.out_load, sts.out_free, "result loaded over a held result")
  `PPM_ASSERT_NEXT(a_last_beat_idle, acc && (state_r == ST_PAYLOAD) && sts.rem_one && !in_end, state_r == ST_IDLE, "payload did not stop after its last beat")
  `PPM_ASSERT_NEXT(a_end_restarts, acc && in_end, (state_r == ST_MAGIC_P) || (state_r == ST_ERR0) || (state_r == ST_MUL), "stream end did not restart the parser")

endmodule

>>> hw/rtl/ppm_p6_stream_parser_top.sv
// Top level of the PPM P6 stream parser: controller plus datapath.
// Payload and error results appear in the cycle after their byte; payload streams at one
// byte per cycle while results are taken, bounded by the single result register.
// The header follows the byte ending the maximum-value token via the multiply, size and
// load states, during which no byte is accepted.
// A truncation error after another result of the same byte waits in its own state.
// rst_n is synchronous and active low; it clears the parser to the magic search.
`timescale 1ns / 1ps
module ppm_p6_stream_parser_top (
  input  logic      clk,
  input  logic      rst_n,
  ppm_byte_if.sink  in_chan,
  ppm_res_if.source out_chan
);

  ppm_pkg::ppm_cmd_t cmd;
  ppm_pkg::ppm_sts_t sts;
  logic              in_ready;

  assign in_chan.ready = in_ready;

  ppm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_end   (in_chan.stream_end),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ppm_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data_byte (in_chan.data_byte),
    .cmd          (cmd),
    .sts          (sts),
    .out_chan     (out_chan)
  );

endmodule
